### rtl/core/lmslu_pkg.sv
// lmslu_pkg: shared constants, config register codes, types and the saturation
// helper for the linear multistep latent update unit. No dependencies.
`default_nettype none

package lmslu_pkg;

    localparam int ORDER_MAX_DEF   = 4;
    localparam int LATENT_SIZE_DEF = 16384;
    localparam int NUM_COEFFS      = 4;
    localparam int DATA_W          = 32;
    localparam int FRAC_W          = 16;
    localparam int ORDER_W         = 3;
    localparam int CFG_IDX_W       = 3;
    localparam int QUEUE_DEPTH     = 2;
    localparam int SAT_W           = 64;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_INV_SIGMA        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORDER            = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_NEWEST     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_BACK_ONE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_BACK_TWO   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_BACK_THREE = 3'd5;

    localparam logic [DATA_W-1:0]  INV_SIGMA_RST = 32'h0001_0000;
    localparam logic [ORDER_W-1:0] ORDER_RST     = 3'd4;

    localparam logic signed [SAT_W-1:0] SAT_HI = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [SAT_W-1:0] SAT_LO = 64'shFFFF_FFFF_8000_0000;

    typedef struct packed {
        logic signed [DATA_W-1:0] sample;
        logic signed [DATA_W-1:0] prediction;
        logic                     last;
    } lmslu_data_t;

    typedef struct packed {
        logic [DATA_W-1:0]                  inv_sigma;
        logic [NUM_COEFFS-1:0][DATA_W-1:0]  coeff;
    } lmslu_arith_cfg_t;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > SAT_HI)
        begin
            r = SAT_HI[DATA_W-1:0];
        end
        else if (v < SAT_LO)
        begin
            r = SAT_LO[DATA_W-1:0];
        end
        else
        begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/core/lmslu_ram.sv
// lmslu_ram: generic single write port, single read port RAM with registered,
// write-first read data. No dependencies.
`default_nettype none

module lmslu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16384,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            // same-cycle write to the read address is passed through
            if (we && (waddr == raddr))
            begin
                rdata_reg <= wdata;
            end
            else
            begin
                rdata_reg <= mem_reg[raddr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### rtl/core/lmslu_fifo.sv
// lmslu_fifo: short register queue between the front and back parts.
// Depends on nothing but its parameters.
`default_nettype none

module lmslu_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data = mem_reg[rd_ptr_reg];
    assign full     = (cnt_reg == CNT_W'(DEPTH));
    assign empty    = (cnt_reg == '0);

endmodule

`default_nettype wire

### rtl/core/lmslu_front.sv
// lmslu_front: input side. Accepts elements, tracks element index, newest
// history slot and fill level, and tags each element. Uses lmslu_pkg.
`default_nettype none

module lmslu_front #(
    parameter int ORDER_MAX   = lmslu_pkg::ORDER_MAX_DEF,
    parameter int LATENT_SIZE = lmslu_pkg::LATENT_SIZE_DEF,
    localparam int IDX_W  = (LATENT_SIZE > 1) ? $clog2(LATENT_SIZE) : 1,
    localparam int SLOT_W = (ORDER_MAX > 1) ? $clog2(ORDER_MAX) : 1,
    localparam int CNT_W  = $clog2(ORDER_MAX + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_last,
    output logic                          in_ready,
    input  logic [lmslu_pkg::ORDER_W-1:0] order,
    input  logic                          q_full,
    output logic                          q_push,
    output logic [IDX_W-1:0]              tag_idx,
    output logic [SLOT_W-1:0]             tag_slot,
    output logic [CNT_W-1:0]              tag_count
);

    import lmslu_pkg::*;

    localparam logic [ORDER_W:0] ORD_MAX_C = (ORDER_W + 1)'(ORDER_MAX);

    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [CNT_W-1:0]  filled_reg, filled_next;
    logic [ORDER_W:0]  ord_ext;
    logic [ORDER_W:0]  ord_clamp;
    logic [CNT_W-1:0]  order_eff;
    logic [CNT_W:0]    fill_inc;
    logic [CNT_W-1:0]  count;

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    // history depth for this element: min(filled + 1, clamped order)
    always_comb
    begin
        ord_ext = {1'b0, order};
        if (ord_ext == '0)
        begin
            ord_clamp = (ORDER_W + 1)'(1);
        end
        else if (ord_ext > ORD_MAX_C)
        begin
            ord_clamp = ORD_MAX_C;
        end
        else
        begin
            ord_clamp = ord_ext;
        end
        order_eff = CNT_W'(ord_clamp);
        fill_inc  = {1'b0, filled_reg} + (CNT_W + 1)'(1);
        count     = (fill_inc > {1'b0, order_eff}) ? order_eff : fill_inc[CNT_W-1:0];
    end

    always_comb
    begin
        idx_next    = idx_reg;
        slot_next   = slot_reg;
        filled_next = filled_reg;
        if (q_push)
        begin
            if (in_last)
            begin
                idx_next    = '0;
                filled_next = count;
                slot_next   = (slot_reg == SLOT_W'(ORDER_MAX - 1)) ? '0 : slot_reg + SLOT_W'(1);
            end
            else
            begin
                idx_next = (idx_reg == IDX_W'(LATENT_SIZE - 1)) ? '0 : idx_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg    <= '0;
            slot_reg   <= '0;
            filled_reg <= '0;
        end
        else
        begin
            idx_reg    <= idx_next;
            slot_reg   <= slot_next;
            filled_reg <= filled_next;
        end
    end

    assign tag_idx   = idx_reg;
    assign tag_slot  = slot_reg;
    assign tag_count = count;

endmodule

`default_nettype wire

### rtl/core/lmslu_back.sv
// lmslu_back: arithmetic pipeline. Derivative, history store per slot,
// weighted terms, sum and saturation. Uses lmslu_pkg and lmslu_ram.
`default_nettype none

module lmslu_back #(
    parameter int ORDER_MAX   = lmslu_pkg::ORDER_MAX_DEF,
    parameter int LATENT_SIZE = lmslu_pkg::LATENT_SIZE_DEF,
    localparam int IDX_W  = (LATENT_SIZE > 1) ? $clog2(LATENT_SIZE) : 1,
    localparam int SLOT_W = (ORDER_MAX > 1) ? $clog2(ORDER_MAX) : 1,
    localparam int CNT_W  = $clog2(ORDER_MAX + 1)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  lmslu_pkg::lmslu_arith_cfg_t         cfg,
    input  logic                                q_empty,
    input  lmslu_pkg::lmslu_data_t              q_item,
    input  logic [IDX_W-1:0]                    q_idx,
    input  logic [SLOT_W-1:0]                   q_slot,
    input  logic [CNT_W-1:0]                    q_count,
    output logic                                q_pop,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [lmslu_pkg::DATA_W-1:0]        next_sample,
    output logic                                step_done
);

    import lmslu_pkg::*;

    localparam int DIFF_W = DATA_W + 1;
    localparam int HALF_W = DATA_W / 2;
    localparam int PART_W = DIFF_W + HALF_W + 1;
    localparam int DW_W   = PART_W + 1;
    localparam int PROD_W = 2 * DATA_W;
    localparam int TERM_W = PROD_W - FRAC_W;
    localparam int PAIR_W = TERM_W + 1;
    localparam int TOT_W  = PAIR_W + 2;

    logic adv;

    // stage 1: partial products of the derivative
    logic signed [DIFF_W-1:0] diff;
    logic signed [HALF_W:0]   inv_lo, inv_hi;
    logic signed [PART_W-1:0] p_lo_next, p_hi_next;
    logic signed [PART_W-1:0] p_lo_reg, p_hi_reg;
    logic signed [DATA_W-1:0] s1_reg;
    logic                     last1_reg;
    logic [IDX_W-1:0]         idx1_reg;
    logic [SLOT_W-1:0]        slot1_reg;
    logic [CNT_W-1:0]         cnt1_reg;
    logic                     v1_reg;

    // stage 2: saturated derivative
    logic signed [DW_W-1:0]   d_wide;
    logic signed [DATA_W-1:0] d_next;
    logic signed [DATA_W-1:0] d2_reg;
    logic signed [DATA_W-1:0] s2_reg;
    logic                     last2_reg;
    logic [IDX_W-1:0]         idx2_reg;
    logic [SLOT_W-1:0]        slot2_reg;
    logic [CNT_W-1:0]         cnt2_reg;
    logic                     v2_reg;

    // stage 3: weighted terms
    logic [DATA_W-1:0]        rd [ORDER_MAX];
    logic signed [PROD_W-1:0] prod0;
    logic signed [TERM_W-1:0] term_next [NUM_COEFFS];
    logic signed [TERM_W-1:0] term_reg [NUM_COEFFS];
    logic signed [DATA_W-1:0] s3_reg;
    logic                     last3_reg;
    logic                     v3_reg;

    // stage 4: pair sums
    logic signed [PAIR_W-1:0] sum_a_reg, sum_b_reg;
    logic signed [DATA_W-1:0] s4_reg;
    logic                     last4_reg;
    logic                     v4_reg;

    // output register
    logic signed [TOT_W-1:0]  total;
    logic [DATA_W-1:0]        next_sample_reg;
    logic                     step_done_reg;
    logic                     out_valid_reg;

    assign adv   = !out_valid_reg || out_ready;
    assign q_pop = adv && !q_empty;

    always_comb
    begin
        diff      = {q_item.sample[DATA_W-1], q_item.sample}
                  - {q_item.prediction[DATA_W-1], q_item.prediction};
        inv_lo    = $signed({1'b0, cfg.inv_sigma[HALF_W-1:0]});
        inv_hi    = $signed({1'b0, cfg.inv_sigma[DATA_W-1:HALF_W]});
        p_lo_next = diff * inv_lo;
        p_hi_next = diff * inv_hi;
    end

    // floor((hi * 2^16 + lo) / 2^16) = hi + floor(lo / 2^16)
    always_comb
    begin
        d_wide = DW_W'(p_hi_reg) + DW_W'(p_lo_reg >>> FRAC_W);
        d_next = sat32(SAT_W'(d_wide));
    end

    for (genvar k = 0; k < ORDER_MAX; k++)
    begin : g_slot
        lmslu_ram #(
            .WIDTH (DATA_W),
            .DEPTH (LATENT_SIZE)
        ) u_hist (
            .clk   (clk),
            .we    (adv && v2_reg && (slot2_reg == SLOT_W'(k))),
            .waddr (idx2_reg),
            .wdata (d2_reg),
            .re    (adv),
            .raddr (idx1_reg),
            .rdata (rd[k])
        );
    end

    always_comb
    begin
        prod0        = $signed(cfg.coeff[0]) * d2_reg;
        term_next[0] = prod0[PROD_W-1:FRAC_W];
    end

    for (genvar j = 1; j < NUM_COEFFS; j++)
    begin : g_lane
        if (j < ORDER_MAX)
        begin : g_hist
            logic [SLOT_W:0]          slot_sum;
            logic [SLOT_W:0]          slot_sel;
            logic signed [DATA_W-1:0] hist;
            logic signed [DATA_W-1:0] coef_eff;
            logic signed [PROD_W-1:0] prod;

            // slot j steps back, and history used only while within the fill count
            always_comb
            begin
                slot_sum = {1'b0, slot2_reg} + (SLOT_W + 1)'(ORDER_MAX - j);
                slot_sel = (slot_sum >= (SLOT_W + 1)'(ORDER_MAX))
                         ? slot_sum - (SLOT_W + 1)'(ORDER_MAX) : slot_sum;
                hist     = (cnt2_reg > CNT_W'(j)) ? $signed(rd[slot_sel[SLOT_W-1:0]]) : '0;
                coef_eff = $signed(cfg.coeff[j]);
                prod     = coef_eff * hist;
                term_next[j] = prod[PROD_W-1:FRAC_W];
            end
        end
        else
        begin : g_none
            assign term_next[j] = '0;
        end
    end

    always_comb
    begin
        total = TOT_W'(s4_reg) + TOT_W'(sum_a_reg) + TOT_W'(sum_b_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg        <= !q_empty;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            out_valid_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_lo_reg  <= p_lo_next;
            p_hi_reg  <= p_hi_next;
            s1_reg    <= q_item.sample;
            last1_reg <= q_item.last;
            idx1_reg  <= q_idx;
            slot1_reg <= q_slot;
            cnt1_reg  <= q_count;

            d2_reg    <= d_next;
            s2_reg    <= s1_reg;
            last2_reg <= last1_reg;
            idx2_reg  <= idx1_reg;
            slot2_reg <= slot1_reg;
            cnt2_reg  <= cnt1_reg;

            for (int i = 0; i < NUM_COEFFS; i++)
            begin
                term_reg[i] <= term_next[i];
            end
            s3_reg    <= s2_reg;
            last3_reg <= last2_reg;

            sum_a_reg <= PAIR_W'(term_reg[0]) + PAIR_W'(term_reg[1]);
            sum_b_reg <= PAIR_W'(term_reg[2]) + PAIR_W'(term_reg[3]);
            s4_reg    <= s3_reg;
            last4_reg <= last3_reg;

            next_sample_reg <= sat32(SAT_W'(total));
            step_done_reg   <= last4_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign next_sample = next_sample_reg;
    assign step_done   = step_done_reg;

endmodule

`default_nettype wire

### rtl/core/linear_multistep_latent_update_unit.sv
// linear_multistep_latent_update_unit: top level with configuration registers,
// front part, element queue and arithmetic back part. Uses lmslu_pkg.
//
// Usage:
//   s_* carries one latent element per transfer: s_tdata = {prediction, sample},
//   s_tlast marks the final element of a scheduler step. m_* returns one
//   updated element per input in order, m_tlast echoing the step end.
//   The user must load registers through cfg_wr_en / cfg_index / cfg_wdata
//   only while idle; the block itself does not enforce it.
// Timing:
//   one element per cycle sustained while the output is not stalled. The rate is
//   set by the derivative history: one RAM per slot, one write and one read port
//   each; all are read on every advance, only the element's slot RAM is written.
// Reset:
//   element index, newest slot and fill count clear, registers take their
//   reset values; history RAMs are not cleared and are only used within the fill count.
// Stall:
//   when m_tvalid is high and m_tready is low the back pipeline holds; the
//   two-entry queue keeps taking elements until full, then s_tready drops.
`default_nettype none

module linear_multistep_latent_update_unit #(
    parameter int ORDER_MAX   = lmslu_pkg::ORDER_MAX_DEF,
    parameter int LATENT_SIZE = lmslu_pkg::LATENT_SIZE_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [2*lmslu_pkg::DATA_W-1:0]  s_tdata,   // sample, prediction
    input  logic                            s_tlast,   // last_element
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [lmslu_pkg::DATA_W-1:0]    m_tdata,   // next_sample
    output logic                            m_tlast,   // step_done
    input  logic                            cfg_wr_en,
    input  logic [lmslu_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lmslu_pkg::DATA_W-1:0]    cfg_wdata
);

    import lmslu_pkg::*;

    localparam int IDX_W  = (LATENT_SIZE > 1) ? $clog2(LATENT_SIZE) : 1;
    localparam int SLOT_W = (ORDER_MAX > 1) ? $clog2(ORDER_MAX) : 1;
    localparam int CNT_W  = $clog2(ORDER_MAX + 1);
    localparam int Q_W    = $bits(lmslu_data_t) + IDX_W + SLOT_W + CNT_W;

    logic [DATA_W-1:0]                 inv_sigma_reg;
    logic [ORDER_W-1:0]                order_reg;
    logic [NUM_COEFFS-1:0][DATA_W-1:0] coeff_reg;
    lmslu_arith_cfg_t                  arith_cfg;

    lmslu_data_t       in_item;
    logic              q_push, q_pop, q_full, q_empty;
    logic [IDX_W-1:0]  tag_idx, q_idx;
    logic [SLOT_W-1:0] tag_slot, q_slot;
    logic [CNT_W-1:0]  tag_count, q_count;
    logic [Q_W-1:0]    q_wr, q_rd;
    lmslu_data_t       q_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_sigma_reg <= INV_SIGMA_RST;
            order_reg     <= ORDER_RST;
            coeff_reg     <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_INV_SIGMA:        inv_sigma_reg <= cfg_wdata;
                REG_ORDER:            order_reg     <= cfg_wdata[ORDER_W-1:0];
                REG_COEFF_NEWEST:     coeff_reg[0]  <= cfg_wdata;
                REG_COEFF_BACK_ONE:   coeff_reg[1]  <= cfg_wdata;
                REG_COEFF_BACK_TWO:   coeff_reg[2]  <= cfg_wdata;
                REG_COEFF_BACK_THREE: coeff_reg[3]  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign arith_cfg.inv_sigma = inv_sigma_reg;
    assign arith_cfg.coeff     = coeff_reg;

    assign in_item.sample     = s_tdata[DATA_W-1:0];
    assign in_item.prediction = s_tdata[2*DATA_W-1:DATA_W];
    assign in_item.last       = s_tlast;

    lmslu_front #(
        .ORDER_MAX   (ORDER_MAX),
        .LATENT_SIZE (LATENT_SIZE)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_last   (s_tlast),
        .in_ready  (s_tready),
        .order     (order_reg),
        .q_full    (q_full),
        .q_push    (q_push),
        .tag_idx   (tag_idx),
        .tag_slot  (tag_slot),
        .tag_count (tag_count)
    );

    assign q_wr = {in_item, tag_idx, tag_slot, tag_count};

    lmslu_fifo #(
        .WIDTH (Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wr),
        .pop       (q_pop),
        .pop_data  (q_rd),
        .full      (q_full),
        .empty     (q_empty)
    );

    assign {q_item, q_idx, q_slot, q_count} = q_rd;

    lmslu_back #(
        .ORDER_MAX   (ORDER_MAX),
        .LATENT_SIZE (LATENT_SIZE)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (arith_cfg),
        .q_empty     (q_empty),
        .q_item      (q_item),
        .q_idx       (q_idx),
        .q_slot      (q_slot),
        .q_count     (q_count),
        .q_pop       (q_pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .next_sample (m_tdata),
        .step_done   (m_tlast)
    );

    // queue never written while full
    assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_full)
        else $error("element queue overflow");

    // queue never read while empty
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> !q_empty)
        else $error("element queue underflow");

    // history depth of an accepted element is between one and the slot count
    assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> ((tag_count != '0) && (tag_count <= CNT_W'(ORDER_MAX))))
        else $error("history depth out of range");

endmodule

`default_nettype wire
